@@ sv/dqs_pkg.sv @@
// Shared types, constants and ring helpers for the deque with search and delete.
`default_nettype none
package dqs_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int OPC_W     = 3;
  localparam int STS_W     = 2;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_DELETE     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop_rd;
    logic    pop_fin;
    logic    scan_start;
    logic    scan_step;
    logic    take_val;
    logic    del_fin;
    logic    clear;
    logic    st_we;
    status_t st;
    logic    out_load;
  } dqs_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic hit;
    logic scan_busy;
  } dqs_sts_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
  endfunction

endpackage
`default_nettype wire

@@ sv/deque_with_search_and_delete_unit.sv @@
// Top level of the bounded deque of signed 32-bit words with find and delete.
// Input channel: in_valid/in_ready with in_opcode (push front, push back,
// pop front, pop back, find, delete value, clear) and in_value.
// Result channel: out_valid/out_ready with out_status, out_result_value and
// out_entry_count; every input word yields exactly one result word.
// One operation is in flight at a time. Each operation is accepted in the
// idle state and passes through the decode state, then the pop or scan
// state for pops, finds and deletes that are not refused, then the
// response state. in_ready rises together with out_valid, so no new input
// word is taken before the previous word's result is ready.
// The scan reads one entry per cycle through the single read port of the
// entry memory; delete shifts later entries one place toward the front as
// the scan passes them, through the write port.
// A finished result sits in the output register; a new input word is taken
// while it waits, but that word's result is held until out_ready takes the
// earlier one, and in_ready stays low meanwhile.
// Synchronous reset (rst_n low) empties the store and drops any pending
// result; entry contents are not cleared and are never read before written.
`default_nettype none
module deque_with_search_and_delete_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic        [dqs_pkg::OPC_W-1:0]  in_opcode,
  input  wire logic signed [dqs_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic             [dqs_pkg::STS_W-1:0]  out_status,
  output logic signed      [dqs_pkg::DATA_W-1:0] out_result_value,
  output logic          [dqs_pkg::OUT_CNT_W-1:0] out_entry_count
);
  import dqs_pkg::*;

  dqs_cmd_t          cmd;
  dqs_sts_t          sts;
  logic [DATA_W-1:0] rv;

  dqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dqs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_status       (out_status),
    .out_result_value (rv),
    .out_entry_count  (out_entry_count)
  );

  assign out_result_value = rv;

endmodule
`default_nettype wire

@@ sv/dqs_dp.sv @@
// Datapath: entry memory, ring pointers, scan pipeline and result registers.
`default_nettype none
module dqs_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dqs_pkg::dqs_cmd_t          cmd,
  output dqs_pkg::dqs_sts_t               sts,
  input  wire logic [dqs_pkg::OPC_W-1:0]  in_opcode,
  input  wire logic [dqs_pkg::DATA_W-1:0] in_value,
  output logic [dqs_pkg::STS_W-1:0]       out_status,
  output logic [dqs_pkg::DATA_W-1:0]      out_result_value,
  output logic [dqs_pkg::OUT_CNT_W-1:0]   out_entry_count
);
  import dqs_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;

  logic [IDX_W-1:0]  front_r, back_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  iss_ptr_r, cmp_ptr_r;
  logic [CNT_W-1:0]  iss_cnt_r;
  logic              cmp_v_r, hit_r;

  op_t               op_r;
  logic [DATA_W-1:0] value_r;
  status_t           st_r;
  logic [DATA_W-1:0] rv_r;
  status_t           out_st_r;
  logic [DATA_W-1:0] out_rv_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa, mem_ra;
  logic [DATA_W-1:0] mem_wd;
  logic              shift_we;

  assign sts.op        = op_r;
  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.hit       = hit_r;
  assign sts.scan_busy = cmp_v_r || (iss_cnt_r != count_r);

  assign shift_we = cmd.scan_step && cmp_v_r && hit_r && (op_r == OP_DELETE);

  always_comb begin
    mem_we = cmd.push || shift_we;
    if (cmd.push) begin
      mem_wa = (op_r == OP_PUSH_FRONT) ? ring_prev(front_r) : ring_next(back_r);
      mem_wd = value_r;
    end else begin
      mem_wa = ring_prev(cmp_ptr_r);
      mem_wd = rd_data_r;
    end
    if (cmd.pop_rd) begin
      mem_ra = (op_r == OP_POP_FRONT) ? front_r : back_r;
    end else begin
      mem_ra = iss_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r   <= '0;
      back_r    <= IDX_W'(CAPACITY - 1);
      count_r   <= '0;
      iss_ptr_r <= '0;
      cmp_ptr_r <= '0;
      iss_cnt_r <= '0;
      cmp_v_r   <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        front_r <= '0;
        back_r  <= IDX_W'(CAPACITY - 1);
        count_r <= '0;
      end
      if (cmd.push) begin
        if (op_r == OP_PUSH_FRONT) begin
          front_r <= ring_prev(front_r);
        end else begin
          back_r <= ring_next(back_r);
        end
        count_r <= count_r + 1'b1;
      end
      if (cmd.pop_fin) begin
        if (op_r == OP_POP_FRONT) begin
          front_r <= ring_next(front_r);
        end else begin
          back_r <= ring_prev(back_r);
        end
        count_r <= count_r - 1'b1;
      end
      if (cmd.del_fin) begin
        back_r  <= ring_prev(back_r);
        count_r <= count_r - 1'b1;
      end
      if (cmd.scan_start) begin
        iss_ptr_r <= front_r;
        iss_cnt_r <= '0;
        cmp_v_r   <= 1'b0;
        hit_r     <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (iss_cnt_r != count_r) begin
          iss_ptr_r <= ring_next(iss_ptr_r);
          iss_cnt_r <= iss_cnt_r + 1'b1;
          cmp_ptr_r <= iss_ptr_r;
          cmp_v_r   <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
        if (cmp_v_r && !hit_r && (rd_data_r == value_r)) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_opcode);
      value_r <= in_value;
      st_r    <= ST_OK;
      rv_r    <= '0;
    end
    if (cmd.st_we) begin
      st_r <= cmd.st;
    end
    if (cmd.pop_fin) begin
      rv_r <= rd_data_r;
    end
    if (cmd.take_val) begin
      rv_r <= value_r;
    end
    if (cmd.out_load) begin
      out_st_r  <= st_r;
      out_rv_r  <= rv_r;
      out_cnt_r <= count_r;
    end
  end

  assign out_status       = out_st_r;
  assign out_result_value = out_rv_r;
  assign out_entry_count  = OUT_CNT_W'(out_cnt_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (ring_next(back_r) == front_r))
    else $error("ends inconsistent on empty store");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r != CNT_W'(CAPACITY)))
    else $error("push on full store");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |=> (cmd.pop_fin && count_r != '0))
    else $error("pop read not followed by pop finish");
`endif

endmodule
`default_nettype wire

@@ sv/dqs_ctrl.sv @@
// Controller: sequences each operation and owns the result word handshake.
`default_nettype none
module dqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire dqs_pkg::dqs_sts_t sts,
  output dqs_pkg::dqs_cmd_t      cmd
);
  import dqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SCAN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESP;
        case (sts.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (sts.full) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_EMPTY;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP;
            end
          end
          OP_FIND, OP_DELETE: begin
            if (sts.empty) begin
              cmd.st_we = 1'b1;
              cmd.st    = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        cmd.pop_fin = 1'b1;
        state_nxt   = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit && (sts.op == OP_FIND || !sts.scan_busy)) begin
          cmd.take_val = 1'b1;
          cmd.del_fin  = (sts.op == OP_DELETE);
          state_nxt    = S_RESP;
        end else if (!sts.scan_busy) begin
          cmd.st_we = 1'b1;
          cmd.st    = ST_NOTFOUND;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire
